### sv/harmonic_bond_energy_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Harmonic bond energy accumulator assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_BOND_ENERGY_ACCUMULATOR_MACROS_SVH
`define HARMONIC_BOND_ENERGY_ACCUMULATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hbe_pkg.sv
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared codes and command/status types of the bond energy accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hbe_pkg;

    localparam int unsigned C_ENERGY_W = 63;
    localparam int unsigned C_K_W      = 32;
    localparam logic [C_ENERGY_W-1:0] C_ENERGY_MAX = '1;

    // Multiplier operand sources
    typedef logic [2:0] t_src;
    localparam t_src SRC_DX  = 3'd0;
    localparam t_src SRC_DY  = 3'd1;
    localparam t_src SRC_DZ  = 3'd2;
    localparam t_src SRC_S   = 3'd3;
    localparam t_src SRC_KS2 = 3'd4;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE    = 3'd0;
    localparam t_op OP_SQ_INIT = 3'd1;
    localparam t_op OP_SQ_STEP = 3'd2;
    localparam t_op OP_STRETCH = 3'd3;
    localparam t_op OP_SAVE_S2 = 3'd4;
    localparam t_op OP_FINISH  = 3'd5;

    typedef struct packed {
        logic load;
        logic mul_go;
        t_src src;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

### sv/hbe_if.sv
// ----------------------------------------------------------------------------
// hbe channel interfaces
// Bond input channel and energy result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbe_in_if #(parameter int unsigned COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic [31:0]                   spring_k;
    logic [31:0]                   rest_length;
    logic                          last_bond;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output spring_k, rest_length, last_bond,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  spring_k, rest_length, last_bond,
        output ready
    );
endinterface

interface hbe_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] total_energy;
    logic        saturated;

    modport source (output valid, total_energy, saturated, input ready);
    modport sink   (input valid, total_energy, saturated, output ready);
endinterface

`default_nettype wire

### sv/harmonic_bond_energy_accumulator.sv
// ----------------------------------------------------------------------------
// Harmonic bond energy accumulator
// Sums k*(r - r0)^2 / 2 over a run of bonds and emits the saturating total.
// ----------------------------------------------------------------------------
// Usage:
//   i_bond carries one bond per transaction: two atom positions, the spring
//   constant, rest length and a last-bond flag. o_energy carries one total
//   per run, sent when the bond with last_bond set has been added; the
//   running sum and the saturation flag then clear for the next run.
//   One bond is worked at a time. The 32x32 multiplier is shared by all
//   products, and the square root yields one bit per cycle. A total
//   appears on o_energy in the cycle after its last bond finishes.
//   Reset clears the sum and flag and drops o_energy.valid; i_bond.ready
//   rises in the cycle after reset is released. A stalled receiver holds the
//   total in the output register; further bonds are still taken, and only a
//   following last bond waits for the slot to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_bond_energy_accumulator import hbe_pkg::*; #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbe_in_if.sink    i_bond,
    hbe_out_if.source o_energy
);

    localparam int unsigned DW   = COORD_WIDTH + 1;
    localparam int unsigned SW   = (DW > 32) ? DW : 32;
    localparam int unsigned NS2C = (2 * SW + 31) / 32;
    localparam int unsigned CIW  = $clog2(NS2C);

    t_cmd           w_cmd;
    t_status        w_status;
    logic [CIW-1:0] w_ci, w_cj;
    logic           w_in_ready;

    assign i_bond.ready = w_in_ready;

    hbe_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bond.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_ci       (w_ci),
        .o_cj       (w_cj)
    );

    hbe_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_ci           (w_ci),
        .i_cj           (w_cj),
        .i_first_x      (i_bond.first_x),
        .i_first_y      (i_bond.first_y),
        .i_first_z      (i_bond.first_z),
        .i_second_x     (i_bond.second_x),
        .i_second_y     (i_bond.second_y),
        .i_second_z     (i_bond.second_z),
        .i_spring_k     (i_bond.spring_k),
        .i_rest_length  (i_bond.rest_length),
        .i_last_bond    (i_bond.last_bond),
        .i_out_ready    (o_energy.ready),
        .o_status       (w_status),
        .o_out_valid    (o_energy.valid),
        .o_total_energy (o_energy.total_energy),
        .o_saturated    (o_energy.saturated)
    );

endmodule

`default_nettype wire

### sv/hbe_ctrl.sv
// ----------------------------------------------------------------------------
// hbe_ctrl
// Sequencer: steps the shared multiplier, square root and accumulate ops.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_ctrl import hbe_pkg::*; #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_status   i_status,
    output t_cmd      o_cmd,
    output logic [$clog2(((2*(((COORD_WIDTH+1) > 32) ? (COORD_WIDTH+1) : 32))+31)/32)-1:0]
                      o_ci,
    output logic [$clog2(((2*(((COORD_WIDTH+1) > 32) ? (COORD_WIDTH+1) : 32))+31)/32)-1:0]
                      o_cj
);

    localparam int unsigned DW   = COORD_WIDTH + 1;
    localparam int unsigned SW   = (DW > 32) ? DW : 32;
    localparam int unsigned S2W  = 2 * SW;
    localparam int unsigned NDC  = (DW + 31) / 32;
    localparam int unsigned NSC  = (SW + 31) / 32;
    localparam int unsigned NS2C = (S2W + 31) / 32;
    localparam int unsigned CIW  = $clog2(NS2C);
    localparam int unsigned CNTW = $clog2(DW);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_SQ_INIT = 3'd3;
    localparam logic [2:0] ST_SQRT    = 3'd4;
    localparam logic [2:0] ST_STRETCH = 3'd5;
    localparam logic [2:0] ST_SAVE    = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]      r_state, n_state;
    t_src            r_src, n_src;
    logic [CIW-1:0]  r_ci, n_ci;
    logic [CIW-1:0]  r_cj, n_cj;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_live;
    logic [CIW-1:0]  w_na_last;
    logic [CIW-1:0]  w_nb_last;

    assign o_in_ready = (r_state == ST_IDLE) && r_live;
    assign o_ci       = r_ci;
    assign o_cj       = r_cj;

    always_comb begin
        case (r_src)
            SRC_KS2: begin
                w_na_last = CIW'(NS2C - 1);
                w_nb_last = '0;
            end
            SRC_S: begin
                w_na_last = CIW'(NSC - 1);
                w_nb_last = CIW'(NSC - 1);
            end
            default: begin
                w_na_last = CIW'(NDC - 1);
                w_nb_last = CIW'(NDC - 1);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_src      = r_src;
        n_ci       = r_ci;
        n_cj       = r_cj;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.src  = r_src;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && r_live) begin
                    o_cmd.load = 1'b1;
                    n_src      = SRC_DX;
                    n_ci       = '0;
                    n_cj       = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (r_cj == w_nb_last) begin
                    n_cj = '0;
                    if (r_ci == w_na_last) begin
                        n_ci = '0;
                        // chain the three squares into one sum
                        case (r_src)
                            SRC_DX:  n_src = SRC_DY;
                            SRC_DY:  n_src = SRC_DZ;
                            default: n_state = ST_DRAIN;
                        endcase
                    end else begin
                        n_ci = r_ci + 1'b1;
                    end
                end else begin
                    n_cj = r_cj + 1'b1;
                end
            end
            ST_DRAIN: begin
                case (r_src)
                    SRC_DZ:  n_state = ST_SQ_INIT;
                    SRC_S:   n_state = ST_SAVE;
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_SQ_INIT: begin
                o_cmd.op = OP_SQ_INIT;
                n_cnt    = CNTW'(DW - 1);
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQ_STEP;
                if (r_cnt == '0) begin
                    n_state = ST_STRETCH;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_STRETCH: begin
                o_cmd.op = OP_STRETCH;
                n_src    = SRC_S;
                n_state  = ST_MUL;
            end
            ST_SAVE: begin
                o_cmd.op = OP_SAVE_S2;
                n_src    = SRC_KS2;
                n_state  = ST_MUL;
            end
            ST_FINISH: begin
                // hold while a finished total still waits at the output
                if (!(i_status.last && i_status.out_busy)) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= SRC_DX;
            r_ci    <= '0;
            r_cj    <= '0;
            r_cnt   <= '0;
            r_live  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_ci    <= n_ci;
            r_cj    <= n_cj;
            r_cnt   <= n_cnt;
            r_live  <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### sv/hbe_dp.sv
// ----------------------------------------------------------------------------
// hbe_dp
// Datapath: chunked multiply-accumulate, bit-serial square root, energy sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_dp import hbe_pkg::*; #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(((2*(((COORD_WIDTH+1) > 32) ? (COORD_WIDTH+1) : 32))+31)/32)-1:0]
                                          i_ci,
    input  logic [$clog2(((2*(((COORD_WIDTH+1) > 32) ? (COORD_WIDTH+1) : 32))+31)/32)-1:0]
                                          i_cj,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    input  logic [C_K_W-1:0]              i_spring_k,
    input  logic [C_K_W-1:0]              i_rest_length,
    input  logic                          i_last_bond,
    input  logic                          i_out_ready,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output logic [C_ENERGY_W-1:0]         o_total_energy,
    output logic                          o_saturated
);

    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned DW   = CW + 1;
    localparam int unsigned SW   = (DW > 32) ? DW : 32;
    localparam int unsigned S2W  = 2 * SW;
    localparam int unsigned PW   = S2W + 32;
    localparam int unsigned NS2C = (S2W + 31) / 32;
    localparam int unsigned CIW  = $clog2(NS2C);
    localparam int unsigned OPW  = NS2C * 32;
    localparam int unsigned SH   = 2 * FRAC_BITS + 1;
    localparam int unsigned RW   = DW;
    localparam int unsigned REMW = RW + 3;

    function automatic logic [DW-1:0] f_abs_diff(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
        logic [DW-1:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d[DW-1] ? (~d + 1'b1) : d;
    endfunction

    // operands and multiplier
    logic [DW-1:0]          r_dx, r_dy, r_dz;
    logic [C_K_W-1:0]       r_k;
    logic [C_K_W-1:0]       r_r0;
    logic                   r_last;
    logic [63:0]            r_pp;
    logic [CIW:0]           r_psh;
    logic                   r_ppv;
    logic [PW-1:0]          r_acc;
    logic [OPW-1:0]         w_a, w_b;
    logic [31:0]            w_a_chunk, w_b_chunk;
    logic [63:0]            w_pp;
    logic [PW-1:0]          w_acc_add;

    // square root
    logic [2*RW-1:0]        r_rad;
    logic [REMW-1:0]        r_rem;
    logic [RW-1:0]          r_root;
    logic [REMW-1:0]        w_rem2, w_trial;
    logic                   w_ge;

    // stretch and energy
    logic [SW-1:0]          r_s;
    logic [S2W-1:0]         r_s2;
    logic [SW-1:0]          w_root_x, w_r0_x, w_s;
    logic [PW-1:0]          w_q;
    logic                   w_ovf;
    logic [C_ENERGY_W:0]    w_sum64;
    logic                   w_clip;
    logic [C_ENERGY_W-1:0]  w_new_sum;
    logic                   w_new_clamp;
    logic [C_ENERGY_W-1:0]  r_sum;
    logic                   r_clamp;
    logic                   r_ov;
    logic [C_ENERGY_W-1:0]  r_oe;
    logic                   r_os;

    always_comb begin
        case (i_cmd.src)
            SRC_DX: begin
                w_a = OPW'(r_dx);
                w_b = OPW'(r_dx);
            end
            SRC_DY: begin
                w_a = OPW'(r_dy);
                w_b = OPW'(r_dy);
            end
            SRC_DZ: begin
                w_a = OPW'(r_dz);
                w_b = OPW'(r_dz);
            end
            SRC_S: begin
                w_a = OPW'(r_s);
                w_b = OPW'(r_s);
            end
            default: begin
                w_a = OPW'(r_s2);
                w_b = OPW'(r_k);
            end
        endcase
    end

    assign w_a_chunk = 32'(w_a >> {i_ci, 5'b0});
    assign w_b_chunk = 32'(w_b >> {i_cj, 5'b0});
    assign w_pp      = 64'(w_a_chunk) * 64'(w_b_chunk);
    assign w_acc_add = r_acc + (PW'(r_pp) << {r_psh, 5'b0});

    // one result bit per step: bring down two radicand bits, try root*4+1
    assign w_rem2  = {r_rem[REMW-3:0], r_rad[2*RW-1 -: 2]};
    assign w_trial = REMW'({r_root, 2'b01});
    assign w_ge    = (w_rem2 >= w_trial);

    assign w_root_x = SW'(r_root);
    assign w_r0_x   = SW'(r_r0);
    assign w_s      = (w_root_x >= w_r0_x) ? (w_root_x - w_r0_x) : (w_r0_x - w_root_x);

    assign w_q         = r_acc >> SH;
    assign w_ovf       = |(w_q >> C_ENERGY_W);
    assign w_sum64     = {1'b0, r_sum} + {1'b0, w_q[C_ENERGY_W-1:0]};
    assign w_clip      = w_ovf | w_sum64[C_ENERGY_W];
    assign w_new_sum   = w_clip ? C_ENERGY_MAX : w_sum64[C_ENERGY_W-1:0];
    assign w_new_clamp = r_clamp | w_clip;

    assign o_status.last     = r_last;
    assign o_status.out_busy = r_ov & ~i_out_ready;
    assign o_out_valid       = r_ov;
    assign o_total_energy    = r_oe;
    assign o_saturated       = r_os;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppv   <= 1'b0;
            r_sum   <= '0;
            r_clamp <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_ppv <= i_cmd.mul_go;
            if ((i_cmd.op == OP_FINISH) && r_last) begin
                r_ov    <= 1'b1;
                r_sum   <= '0;
                r_clamp <= 1'b0;
            end else begin
                if (r_ov && i_out_ready) begin
                    r_ov <= 1'b0;
                end
                if (i_cmd.op == OP_FINISH) begin
                    r_sum   <= w_new_sum;
                    r_clamp <= w_new_clamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= f_abs_diff(i_first_x, i_second_x);
            r_dy   <= f_abs_diff(i_first_y, i_second_y);
            r_dz   <= f_abs_diff(i_first_z, i_second_z);
            r_k    <= i_spring_k;
            r_r0   <= i_rest_length;
            r_last <= i_last_bond;
        end
        r_pp  <= w_pp;
        r_psh <= {1'b0, i_ci} + {1'b0, i_cj};

        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= w_acc_add;
        end else begin
            case (i_cmd.op)
                OP_STRETCH, OP_SAVE_S2: r_acc <= '0;
                default:                r_acc <= r_acc;
            endcase
        end

        case (i_cmd.op)
            OP_SQ_INIT: begin
                r_rad  <= r_acc[2*RW-1:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQ_STEP: begin
                r_rad  <= {r_rad[2*RW-3:0], 2'b00};
                r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
                r_root <= {r_root[RW-2:0], w_ge};
            end
            OP_STRETCH: begin
                r_s <= w_s;
            end
            OP_SAVE_S2: begin
                r_s2 <= r_acc[S2W-1:0];
            end
            OP_FINISH: begin
                if (r_last) begin
                    r_oe <= w_new_sum;
                    r_os <= w_new_clamp;
                end
            end
            default: begin
                r_s <= r_s;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/hbe_checker.sv
// ----------------------------------------------------------------------------
// hbe_checker
// Port-level checks of the bond energy accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "harmonic_bond_energy_accumulator_macros.svh"

module hbe_checker import hbe_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [C_ENERGY_W-1:0] i_total_energy,
    input logic                  i_saturated
);

    `HBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `HBE_ASSERT_SAME(a_sat_at_max, i_clk, i_rst_n, i_out_valid && i_saturated, i_total_energy == C_ENERGY_MAX, "saturated total below maximum")
    `HBE_ASSERT_NEXT(a_one_bond, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second bond taken while one is in work")
    `HBE_ASSERT_SAME(a_no_early_total, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready), "total appeared right after a bond transaction")

endmodule

bind harmonic_bond_energy_accumulator hbe_checker u_hbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_bond.valid),
    .i_in_ready     (i_bond.ready),
    .i_out_valid    (o_energy.valid),
    .i_out_ready    (o_energy.ready),
    .i_total_energy (o_energy.total_energy),
    .i_saturated    (o_energy.saturated)
);

`default_nettype wire
